>>> hw/rtl/aobs_pkg.sv
// Package for the operand barrel shifter: shift kinds, instruction field codes,
// the staged word type and the shift step shared by the pipeline stages.
// No dependencies.
`default_nettype none

package aobs_pkg;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] PC_INDEX = 4'd15;
    localparam logic [3:0] PC_ADJ_IMM = 4'd4;
    localparam logic [3:0] PC_ADJ_REG = 4'd8;
    localparam logic [7:0] SHAMT_FULL = 8'd32;

    typedef enum logic [1:0] {
        KIND_LSL = 2'd0,
        KIND_LSR = 2'd1,
        KIND_ASR = 2'd2,
        KIND_ROR = 2'd3
    } shift_kind_t;

    // LSL keeps {carry, value}; the other kinds keep {value, carry}.
    typedef struct packed {
        shift_kind_t kind;
        logic [4:0]  shamt;
        logic [32:0] w;
    } stage_t;

    function automatic logic [32:0] shift_step(
        input shift_kind_t kind,
        input logic [32:0] w,
        input logic [4:0]  n
    );
        logic [63:0] dbl;
        logic [32:0] res;
        begin
            dbl = {w[32:1], w[32:1]} >> n;
            case (kind)
                KIND_LSL: res = w << n;
                KIND_LSR: res = w >> n;
                KIND_ASR: res = 33'($signed(w) >>> n);
                KIND_ROR: res = {dbl[31:0], w[0]};
                default:  res = w;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/aobs_if.sv
// Channel interfaces for the operand barrel shifter: instruction items in,
// operand items out. No dependencies.
`default_nettype none

interface aobs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr;
    logic        imm_form;
    logic        reg_shift;
    logic [31:0] rm_value;
    logic [31:0] rs_value;
    logic        carry_in;

    modport source (
        output valid, instr, imm_form, reg_shift, rm_value, rs_value, carry_in,
        input  ready
    );
    modport sink (
        input  valid, instr, imm_form, reg_shift, rm_value, rs_value, carry_in,
        output ready
    );
endinterface

interface aobs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand;
    logic        carry_out;

    modport source (
        output valid, operand, carry_out,
        input  ready
    );
    modport sink (
        input  valid, operand, carry_out,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/arm_operand_barrel_shifter_top.sv
// Operand barrel shifter: decode, coarse shift, fine shift, one register each.
// An accepted item passes through the decode, coarse and fine registers in turn;
// throughput is one item per cycle while the output is ready, set by the
// three-stage pipeline with per-stage stall.
// Reset clears the valid bits of all stages; payload registers are not reset.
// Depends on aobs_pkg, aobs_if and aobs_shift_stage.
`default_nettype none

module arm_operand_barrel_shifter_top
    import aobs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    aobs_in_if.sink    in_ch,
    aobs_out_if.source out_ch
);

    logic        s1_valid_reg;
    stage_t      s1_data_reg;
    stage_t      s1_data_next;
    logic        s2_in_ready;
    logic        s2_valid;
    stage_t      s2_data;
    logic        s3_in_ready;
    logic        s3_valid;
    stage_t      s3_data;

    logic [31:0] rm_adj;
    logic [7:0]  amt8;
    logic [1:0]  sh_type;
    logic [7:0]  imm8;
    logic [3:0]  rot4;

    assign imm8    = in_ch.instr[7:0];
    assign rot4    = in_ch.instr[11:8];
    assign sh_type = in_ch.instr[6:5];
    assign amt8    = in_ch.reg_shift ? in_ch.rs_value[7:0] : {3'b000, in_ch.instr[11:7]};

    always_comb
    begin
        rm_adj = in_ch.rm_value;
        if (in_ch.instr[3:0] == PC_INDEX)
        begin
            rm_adj = in_ch.rm_value
                   + {28'd0, (in_ch.reg_shift ? PC_ADJ_REG : PC_ADJ_IMM)};
        end
    end

    always_comb
    begin
        s1_data_next.kind  = KIND_LSR;
        s1_data_next.shamt = 5'd0;
        s1_data_next.w     = {rm_adj, in_ch.carry_in};
        if (in_ch.imm_form)
        begin
            if (rot4 == 4'd0)
            begin
                s1_data_next.w = {24'd0, imm8, in_ch.carry_in};
            end
            else
            begin
                s1_data_next.kind  = KIND_ROR;
                s1_data_next.shamt = {rot4, 1'b0};
                s1_data_next.w     = {24'd0, imm8, 1'b0};
            end
        end
        else if (amt8 == 8'd0)
        begin
            if (!in_ch.reg_shift && sh_type == SH_LSR)
            begin
                s1_data_next.w = {32'd0, rm_adj[31]};
            end
            else if (!in_ch.reg_shift && sh_type == SH_ASR)
            begin
                s1_data_next.w = {33{rm_adj[31]}};
            end
            else if (!in_ch.reg_shift && sh_type == SH_ROR)
            begin
                s1_data_next.w = {in_ch.carry_in, rm_adj};
            end
        end
        else
        begin
            case (sh_type)
                SH_LSL:
                begin
                    if (amt8 < SHAMT_FULL)
                    begin
                        s1_data_next.kind  = KIND_LSL;
                        s1_data_next.shamt = amt8[4:0];
                        s1_data_next.w     = {1'b0, rm_adj};
                    end
                    else if (amt8 == SHAMT_FULL)
                    begin
                        s1_data_next.w = {32'd0, rm_adj[0]};
                    end
                    else
                    begin
                        s1_data_next.w = 33'd0;
                    end
                end
                SH_LSR:
                begin
                    if (amt8 < SHAMT_FULL)
                    begin
                        s1_data_next.kind  = KIND_LSR;
                        s1_data_next.shamt = amt8[4:0];
                        s1_data_next.w     = {rm_adj, 1'b0};
                    end
                    else if (amt8 == SHAMT_FULL)
                    begin
                        s1_data_next.w = {32'd0, rm_adj[31]};
                    end
                    else
                    begin
                        s1_data_next.w = 33'd0;
                    end
                end
                SH_ASR:
                begin
                    if (amt8 < SHAMT_FULL)
                    begin
                        s1_data_next.kind  = KIND_ASR;
                        s1_data_next.shamt = amt8[4:0];
                        s1_data_next.w     = {rm_adj, 1'b0};
                    end
                    else
                    begin
                        s1_data_next.w = {33{rm_adj[31]}};
                    end
                end
                default:
                begin
                    if (amt8[4:0] == 5'd0)
                    begin
                        s1_data_next.w = {rm_adj, rm_adj[31]};
                    end
                    else
                    begin
                        s1_data_next.kind  = KIND_ROR;
                        s1_data_next.shamt = amt8[4:0];
                        s1_data_next.w     = {rm_adj, 1'b0};
                    end
                end
            endcase
        end
    end

    assign in_ch.ready = !s1_valid_reg || s2_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_data_reg <= s1_data_next;
        end
    end

    aobs_shift_stage u_coarse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (s2_in_ready),
        .in_data   (s1_data_reg),
        .amt       ({s1_data_reg.shamt[4:2], 2'b00}),
        .out_valid (s2_valid),
        .out_ready (s3_in_ready),
        .out_data  (s2_data)
    );

    aobs_shift_stage u_fine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s3_in_ready),
        .in_data   (s2_data),
        .amt       ({3'b000, s2_data.shamt[1:0]}),
        .out_valid (s3_valid),
        .out_ready (out_ch.ready),
        .out_data  (s3_data)
    );

    assign out_ch.valid = s3_valid;

    always_comb
    begin
        case (s3_data.kind)
            KIND_LSL:
            begin
                out_ch.operand   = s3_data.w[31:0];
                out_ch.carry_out = s3_data.w[32];
            end
            KIND_ROR:
            begin
                out_ch.operand   = s3_data.w[32:1];
                out_ch.carry_out = s3_data.w[32];
            end
            default:
            begin
                out_ch.operand   = s3_data.w[32:1];
                out_ch.carry_out = s3_data.w[0];
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ror_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.kind == KIND_ROR) |-> (s1_data_reg.shamt != 5'd0))
        else $error("rotate item with zero amount in decode stage");

    a_lsl_top_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_data_reg.kind == KIND_LSL) |-> (s1_data_reg.w[32] == 1'b0))
        else $error("left shift item with stray carry bit in decode stage");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid && !s3_in_ready) |=> (s2_valid && $stable(s2_data)))
        else $error("coarse stage item lost under stall");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_in_ready) |=> (s1_valid_reg && $stable(s1_data_reg)))
        else $error("decode stage item lost under stall");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/aobs_shift_stage.sv
// One registered shift stage of the operand barrel shifter pipeline.
// Depends on aobs_pkg.
`default_nettype none

module aobs_shift_stage
    import aobs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire stage_t     in_data,
    input  wire logic [4:0] amt,
    output logic            out_valid,
    input  wire logic       out_ready,
    output stage_t          out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next   = in_data;
        data_next.w = shift_step(in_data.kind, in_data.w, amt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> verif/arm_operand_barrel_shifter_top_tb.sv
// Testbench for arm_operand_barrel_shifter_top: drives operand requests through the
// input channel and checks every operand and carry-out against a built-in predictor.
// Depends on aobs_pkg, aobs_if and the shifter RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [31:0] instr;
    logic        imm_form;
    logic        reg_shift;
    logic [31:0] rm_value;
    logic [31:0] rs_value;
    logic        carry_in;
} shifter_req_t;

typedef struct packed {
    logic [31:0] operand;
    logic        carry_out;
} shifter_res_t;

class operand_checker;
    shifter_res_t expected_operands[$];
    int           err_count;

    function new();
        err_count = 0;
    endfunction

    static function logic [31:0] rotate_right(logic [31:0] v, logic [4:0] n);
        return (v >> n) | (v << (6'd32 - {1'b0, n}));
    endfunction

    static function shifter_res_t predict_operand2(shifter_req_t r);
        shifter_res_t          o;
        logic [4:0]            rot;
        logic [31:0]           rm;
        logic [7:0]            amt;
        aobs_pkg::shift_kind_t kind;
        logic [32:0]           w;
        if (r.imm_form)
        begin
            rot = {r.instr[11:8], 1'b0};
            o.operand = rotate_right({24'd0, r.instr[7:0]}, rot);
            o.carry_out = (rot == 5'd0) ? r.carry_in : o.operand[31];
            return o;
        end
        kind = aobs_pkg::shift_kind_t'(r.instr[6:5]);
        rm = r.rm_value;
        if (r.instr[3:0] == aobs_pkg::PC_INDEX)
            rm = rm + (r.reg_shift ? 32'(aobs_pkg::PC_ADJ_REG) : 32'(aobs_pkg::PC_ADJ_IMM));
        amt = r.reg_shift ? r.rs_value[7:0] : {3'd0, r.instr[11:7]};
        o.operand = rm;
        o.carry_out = r.carry_in;
        if (amt == 8'd0 && !r.reg_shift)
        begin
            if (kind == aobs_pkg::KIND_ROR)
            begin
                o.operand = {r.carry_in, rm[31:1]};
                o.carry_out = rm[0];
            end
            else if (kind != aobs_pkg::KIND_LSL)
                amt = aobs_pkg::SHAMT_FULL;
        end
        if (amt != 8'd0)
        begin
            case (kind)
                aobs_pkg::KIND_LSL:
                    if (amt < aobs_pkg::SHAMT_FULL)
                    begin
                        w = {1'b0, rm} << amt;
                        o.operand = w[31:0];
                        o.carry_out = w[32];
                    end
                    else
                    begin
                        o.operand = 32'd0;
                        o.carry_out = (amt == aobs_pkg::SHAMT_FULL) ? rm[0] : 1'b0;
                    end
                aobs_pkg::KIND_LSR:
                    if (amt < aobs_pkg::SHAMT_FULL)
                    begin
                        w = {rm, 1'b0} >> amt;
                        o.operand = w[32:1];
                        o.carry_out = w[0];
                    end
                    else
                    begin
                        o.operand = 32'd0;
                        o.carry_out = (amt == aobs_pkg::SHAMT_FULL) ? rm[31] : 1'b0;
                    end
                aobs_pkg::KIND_ASR:
                    if (amt < aobs_pkg::SHAMT_FULL)
                    begin
                        w = 33'($signed({rm, 1'b0}) >>> amt);
                        o.operand = w[32:1];
                        o.carry_out = w[0];
                    end
                    else
                    begin
                        o.operand = {32{rm[31]}};
                        o.carry_out = rm[31];
                    end
                default:
                    begin
                        o.operand = rotate_right(rm, amt[4:0]);
                        o.carry_out = o.operand[31];
                    end
            endcase
        end
        return o;
    endfunction

    function void note_item(shifter_req_t r);
        expected_operands.push_back(predict_operand2(r));
    endfunction

    function void check_result(logic [31:0] operand, logic carry_out);
        shifter_res_t e;
        if (expected_operands.size() == 0)
        begin
            $display("%0t: unexpected result operand %h carry %b", $time, operand, carry_out);
            err_count++;
            return;
        end
        e = expected_operands.pop_front();
        if (operand !== e.operand)
        begin
            $display("%0t: operand mismatch expected %h actual %h", $time, e.operand, operand);
            err_count++;
        end
        if (carry_out !== e.carry_out)
        begin
            $display("%0t: carry_out mismatch expected %b actual %b",
                     $time, e.carry_out, carry_out);
            err_count++;
        end
    endfunction

    function int pending();
        return expected_operands.size();
    endfunction
endclass

module arm_operand_barrel_shifter_top_tb;
    import aobs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RX_HOLD     = 300;
    localparam int PHASE_ITEMS = 250;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_stall_pct;
    bit   hold_rx;
    int   quiet_cycles;

    operand_checker checker_q;

    aobs_in_if  in_ch ();
    aobs_out_if out_ch ();

    arm_operand_barrel_shifter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic shifter_req_t make_req(logic [31:0] instr, logic imm_form,
                                              logic reg_shift, logic [31:0] rm,
                                              logic [31:0] rs, logic cin);
        shifter_req_t r;
        r.instr = instr;
        r.imm_form = imm_form;
        r.reg_shift = reg_shift;
        r.rm_value = rm;
        r.rs_value = rs;
        r.carry_in = cin;
        return r;
    endfunction

    function automatic shifter_req_t random_req();
        shifter_req_t r;
        r = make_req($urandom(), $urandom_range(2) == 0, 1'($urandom_range(1)), $urandom(),
                     $urandom(), 1'($urandom_range(1)));
        if ($urandom_range(7) == 0)
            r.instr[3:0] = PC_INDEX;
        if ($urandom_range(3) == 0)
            r.instr[11:7] = 5'd0;
        case ($urandom_range(3))
            0: r.rs_value[7:0] = 8'($urandom_range(40));
            1: r.rs_value[7:0] = {3'($urandom_range(7)), 5'd0};
            default: ;
        endcase
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: r.rm_value = 32'h0000_0000;
                1: r.rm_value = 32'hFFFF_FFFF;
                2: r.rm_value = 32'h8000_0000;
                default: r.rm_value = 32'hFFFF_FFFC;
            endcase
        end
        return r;
    endfunction

    // Encode the register form: amount in 11:7, kind in 6:5, Rm index in 3:0.
    function automatic logic [31:0] reg_instr(logic [4:0] amt, logic [1:0] kind,
                                              logic [3:0] rm_idx);
        logic [31:0] v;
        v = $urandom();
        v[11:7] = amt;
        v[6:5] = kind;
        v[3:0] = rm_idx;
        return v;
    endfunction

    task automatic send_item(input shifter_req_t r);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.instr     <= r.instr;
        in_ch.imm_form  <= r.imm_form;
        in_ch.reg_shift <= r.reg_shift;
        in_ch.rm_value  <= r.rm_value;
        in_ch.rs_value  <= r.rs_value;
        in_ch.carry_in  <= r.carry_in;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (checker_q.pending() != 0)
            @(negedge clk);
    endtask

    task automatic set_phase(input int tx_pct, input int rx_pct);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_req());
    endtask

    always @(negedge clk)
        out_ch.ready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                checker_q.note_item(make_req(in_ch.instr, in_ch.imm_form, in_ch.reg_shift,
                                             in_ch.rm_value, in_ch.rs_value,
                                             in_ch.carry_in));
            if (out_ch.valid && out_ch.ready)
                checker_q.check_result(out_ch.operand, out_ch.carry_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        checker_q = new();
        rst_n = 1'b0;
        hold_rx = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        quiet_cycles = 0;
        in_ch.valid = 1'b0;
        in_ch.instr = '0;
        in_ch.imm_form = 1'b0;
        in_ch.reg_shift = 1'b0;
        in_ch.rm_value = '0;
        in_ch.rs_value = '0;
        in_ch.carry_in = 1'b0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // immediate form: rotate zero, rotate nonzero, widest rotate
        send_item(make_req(32'h0000_00FF, 1'b1, 1'b0, $urandom(), $urandom(), 1'b1));
        send_item(make_req(32'hFFFF_F1FF, 1'b1, 1'b1, $urandom(), $urandom(), 1'b0));
        send_item(make_req(32'h0000_0F80, 1'b1, 1'b0, $urandom(), $urandom(), 1'b0));
        send_item(make_req(32'h0000_0A01, 1'b1, 1'b0, $urandom(), $urandom(), 1'b1));
        // immediate amount zero: LSL passes, LSR/ASR mean 32, ROR means RRX; then 31 for LSL, ASR
        send_item(make_req(reg_instr(5'd0, SH_LSL, 4'd1), 1'b0, 1'b0, 32'h8000_0001,
                           '0, 1'b1));
        send_item(make_req(reg_instr(5'd0, SH_LSR, 4'd2), 1'b0, 1'b0, 32'h8000_0000,
                           '0, 1'b0));
        send_item(make_req(reg_instr(5'd0, SH_ASR, 4'd3), 1'b0, 1'b0, 32'h8000_0000,
                           '0, 1'b0));
        send_item(make_req(reg_instr(5'd0, SH_ASR, 4'd3), 1'b0, 1'b0, 32'h7FFF_FFFF,
                           '0, 1'b1));
        send_item(make_req(reg_instr(5'd0, SH_ROR, 4'd4), 1'b0, 1'b0, 32'h0000_0003,
                           '0, 1'b1));
        send_item(make_req(reg_instr(5'd31, SH_LSL, 4'd5), 1'b0, 1'b0, 32'hFFFF_FFFF,
                           '0, 1'b0));
        send_item(make_req(reg_instr(5'd31, SH_ASR, 4'd5), 1'b0, 1'b0, 32'h8000_0000,
                           '0, 1'b0));
        // register amounts: zero, exactly 32, just above 32, for every kind; then ROR 64, LSL 255
        for (int k = 0; k < 4; k++)
        begin
            send_item(make_req(reg_instr(5'd0, k[1:0], 4'd6), 1'b0, 1'b1, 32'h8000_0001,
                               32'hFFFF_FF00, 1'b1));
            send_item(make_req(reg_instr(5'd0, k[1:0], 4'd7), 1'b0, 1'b1, 32'h8000_0001,
                               32'h0000_0020, 1'b0));
            send_item(make_req(reg_instr(5'd0, k[1:0], 4'd8), 1'b0, 1'b1, 32'hC000_0001,
                               32'h0000_0021, 1'b0));
        end
        send_item(make_req(reg_instr(5'd0, SH_ROR, 4'd9), 1'b0, 1'b1, 32'h8000_0000,
                           32'h0000_0040, 1'b0));
        send_item(make_req(reg_instr(5'd0, SH_LSL, 4'd9), 1'b0, 1'b1, 32'hFFFF_FFFF,
                           32'h0000_00FF, 1'b1));
        // Rm is the PC, with wraparound
        send_item(make_req(reg_instr(5'd0, SH_LSL, PC_INDEX), 1'b0, 1'b0, 32'hFFFF_FFFC,
                           '0, 1'b0));
        send_item(make_req(reg_instr(5'd0, SH_LSR, PC_INDEX), 1'b0, 1'b1, 32'hFFFF_FFFC,
                           32'h0000_0004, 1'b0));
        drain_results();

        set_phase(0, 0);
        run_random(PHASE_ITEMS);
        set_phase(70, 0);
        run_random(PHASE_ITEMS);
        drain_results();
        set_phase(0, 70);
        run_random(PHASE_ITEMS);
        set_phase(35, 35);
        run_random(PHASE_ITEMS);

        // hold the output long enough for the pipeline to back up into the input
        set_phase(0, 0);
        fork
            begin
                @(posedge clk);
                hold_rx = 1'b1;
                repeat (RX_HOLD) @(posedge clk);
                hold_rx = 1'b0;
            end
        join_none
        run_random(100);

        in_ch.valid <= 1'b0;
        drain_results();
        repeat (10) @(negedge clk);
        if (checker_q.err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> arm_operand_barrel_shifter_top.f
hw/rtl/aobs_pkg.sv
hw/rtl/aobs_if.sv
hw/rtl/aobs_shift_stage.sv
hw/rtl/arm_operand_barrel_shifter_top.sv
verif/arm_operand_barrel_shifter_top_tb.sv
